FILE: rtl/tcupr_pkg.sv
// ----------------------------------------------------------------------------
// Two-core utility partition replacer package
// Types and constants shared by the replacement engine.
// ----------------------------------------------------------------------------
package tcupr_pkg;

    localparam int SETS_DEFAULT = 1024;
    localparam int WAYS         = 16;

    localparam logic [31:0] INTERVAL_RESET = 32'd1000000;
    localparam logic [3:0]  BOTTOM_RESET   = 4'd15;
    localparam logic [3:0]  QUOTA_RESET    = 4'd8;
    localparam logic [4:0]  NEVER_FILLED   = 5'd19;
    localparam logic [47:0] MARK_MAX       = 48'hFFFF_FFFF_FFFF;

    localparam logic        FUNC_HIT  = 1'b0;
    localparam logic        FUNC_FILL = 1'b1;

    localparam logic        CFG_INTERVAL = 1'b0;
    localparam logic        CFG_BOTTOM   = 1'b1;

    typedef struct packed {
        logic        func;
        logic [9:0]  set_index;
        logic [3:0]  hit_way;
        logic        core;
        logic [15:0] valid_mask;
        logic [47:0] cycle_now;
    } t_in;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       filled_invalid;
        logic       repartitioned;
        logic [3:0] core0_ways;
    } t_out;

    typedef struct packed {
        logic       owner;
        logic [4:0] pos;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

endpackage

FILE: rtl/two_core_utility_partition_replacer_unit.sv
// ----------------------------------------------------------------------------
// Two-core utility partition replacer
// Recency and owner state of a 16-way cache shared by two cores, with victim
// selection and periodic utility-based way partitioning.
// ----------------------------------------------------------------------------
// After reset the block clears every set of its set memory and accepts no
// word during that pass. Words are then handled one at a time. A hit passes
// through accept, set memory read and write-back. A fill passes through
// accept, the read, a scan of the ways for owner counts and LRU blocks, a
// bit-serial division of the cycle count by the interval, one check and the
// write-back; a repartition adds the two passes over the hit counters. When
// SETS is below 1024, the set index is reduced modulo SETS as the word is
// accepted. The input is ready again once the result is in the output
// register, which holds it until it is taken.
module two_core_utility_partition_replacer_unit #(
    parameter int SETS = tcupr_pkg::SETS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tcupr_pkg::t_in   i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tcupr_pkg::t_out  o_out
);
    import tcupr_pkg::*;

    localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam bit NEED_MOD = (SETS < 1024);
    localparam logic [SW-1:0] LAST_SET = SW'(SETS - 1);
    localparam int MOD_SH = 24;
    localparam logic [24:0] MOD_M = 25'((1 << MOD_SH) / SETS + 1);

    typedef enum logic [9:0] {
        ST_CLR   = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_RD    = 10'b0000000100,
        ST_SCAN  = 10'b0000001000,
        ST_DIV   = 10'b0000010000,
        ST_CHK   = 10'b0000100000,
        ST_REP1  = 10'b0001000000,
        ST_REP2  = 10'b0010000000,
        ST_APPLY = 10'b0100000000,
        ST_SPARE = 10'b1000000000
    } t_state;

    t_row mem [SETS];

    t_state      r_state, n_state;
    logic [SW-1:0] r_clr;
    logic [SW-1:0] r_set;
    t_in         r_in;
    t_row        r_row;
    logic [5:0]  r_k;
    logic [31:0] r_iv;
    logic [3:0]  r_sb;
    logic [3:0]  r_quota;
    logic [47:0] r_mark;
    logic [31:0] r_h0 [WAYS];
    logic [31:0] r_h1 [WAYS];
    logic [35:0] r_p1 [WAYS];
    logic [35:0] r_acc;
    logic [36:0] r_best;
    logic [3:0]  r_bestj;
    logic [31:0] r_rem;
    logic [47:0] r_quo;
    logic [4:0]  r_n0;
    logic        r_has0, r_has1;
    logic [4:0]  r_b0, r_b1;
    logic [3:0]  r_l0, r_l1;
    logic        r_rep;
    logic        r_ov;
    t_out        r_out;

    logic [3:0]  h_idx;
    logic [31:0] h0, h1;
    logic [31:0] iv_eff;
    logic [32:0] div_t;
    logic        div_bit;
    logic [34:0] mod_prod;
    logic [9:0]  mod_q;
    logic [9:0]  mod_lo;
    logic [9:0]  set_red;
    t_way        sw;
    logic [35:0] s0;
    logic [36:0] util;
    logic        util_take;
    logic [4:0]  hp;
    t_row        hrow, frow, n_row;
    logic        inv_found;
    logic [3:0]  inv_way;
    logic        take;
    logic [3:0]  vic;
    logic [3:0]  sb_eff;
    logic [4:0]  tgt;
    logic        do_place;
    logic        t_found;
    logic [3:0]  t_way_i;
    logic        out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
    assign out_free    = !r_ov || i_out_ready;

    assign iv_eff  = (r_iv == 32'd0) ? 32'd1 : r_iv;
    assign div_t   = {r_rem, r_quo[47]};
    assign div_bit = (div_t >= {1'b0, iv_eff});

    assign mod_prod = 35'(i_in.set_index) * 35'(MOD_M);
    assign mod_q    = mod_prod[MOD_SH +: 10];
    assign mod_lo   = mod_q * 10'(SETS);
    assign set_red  = i_in.set_index - mod_lo;

    assign hp    = r_row[r_in.hit_way].pos;
    assign h_idx = (r_state == ST_APPLY) ? hp[3:0] : r_k[3:0];
    assign h0    = r_h0[h_idx];
    assign h1    = r_h1[h_idx];

    assign sw        = r_row[r_k[3:0]];
    assign s0        = r_acc + 36'(h0);
    assign util      = 37'(s0) + 37'(r_p1[~r_k[3:0]]);
    assign util_take = (r_k == 6'd0) || (util > r_best);

    assign sb_eff = (r_sb < 4'd2) ? 4'd2 : r_sb;

    always_comb begin
        hrow = r_row;
        for (int i = 0; i < WAYS; i++) begin
            if (r_row[i].pos < hp) begin
                hrow[i].pos = r_row[i].pos + 5'd1;
            end
        end
        hrow[r_in.hit_way].pos = 5'd0;

        inv_found = 1'b0;
        inv_way   = 4'd0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (!r_in.valid_mask[i]) begin
                inv_found = 1'b1;
                inv_way   = 4'(i);
            end
        end

        if ({1'b0, r_quota} > r_n0) begin
            take = 1'b1;
        end else if ({1'b0, r_quota} < r_n0) begin
            take = 1'b0;
        end else begin
            take = r_in.core;
        end
        if (!take && !r_has0) begin
            take = 1'b1;
        end
        if (take && !r_has1) begin
            take = 1'b0;
        end

        vic      = inv_found ? inv_way : (take ? r_l1 : r_l0);
        tgt      = inv_found ? {1'b0, sb_eff - 4'd1} : r_row[vic].pos - 5'd1;
        do_place = inv_found || (r_row[vic].pos != 5'd0);

        t_found = 1'b0;
        t_way_i = 4'd0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (r_row[i].pos == tgt) begin
                t_found = 1'b1;
                t_way_i = 4'(i);
            end
        end

        frow = r_row;
        if (do_place) begin
            if (t_found) begin
                frow[t_way_i].pos = r_row[t_way_i].pos + 5'd1;
            end
            frow[vic].pos = tgt;
        end
        frow[vic].owner = r_in.core;

        n_row = (r_in.func == FUNC_HIT) ? hrow : frow;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR: begin
                if (r_clr == LAST_SET) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = (r_in.func == FUNC_FILL) ? ST_SCAN : ST_APPLY;
            end
            ST_SCAN: begin
                if (r_k == 6'd15) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_k == 6'd47) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                n_state = (r_quo >= r_mark) ? ST_REP1 : ST_APPLY;
            end
            ST_REP1: begin
                if (r_k == 6'd14) begin
                    n_state = ST_REP2;
                end
            end
            ST_REP2: begin
                if (r_k == 6'd14) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLR) begin
            mem[r_clr] <= {WAYS{t_way'({1'b0, NEVER_FILLED})}};
        end else if (r_state == ST_APPLY && out_free) begin
            mem[r_set] <= n_row;
        end
        if (r_state == ST_RD) begin
            r_row <= mem[r_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_k     <= '0;
            r_iv    <= INTERVAL_RESET;
            r_sb    <= BOTTOM_RESET;
            r_quota <= QUOTA_RESET;
            r_mark  <= 48'd1;
            r_ov    <= 1'b0;
            for (int i = 0; i < WAYS; i++) begin
                r_h0[i] <= '0;
                r_h1[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INTERVAL: r_iv <= i_cfg_data;
                    CFG_BOTTOM:   r_sb <= i_cfg_data[3:0];
                    default:      r_sb <= r_sb;
                endcase
            end
            if (r_state == ST_APPLY && out_free) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + SW'(1);
                end
                ST_IDLE: begin
                    r_k <= '0;
                    if (i_in_valid) begin
                        r_in  <= i_in;
                        r_set <= NEED_MOD ? SW'(set_red) : SW'(i_in.set_index);
                    end
                end
                ST_RD: begin
                    r_k    <= '0;
                    r_n0   <= '0;
                    r_has0 <= 1'b0;
                    r_has1 <= 1'b0;
                    r_rep  <= 1'b0;
                    r_rem  <= '0;
                    r_quo  <= r_in.cycle_now;
                end
                ST_SCAN: begin
                    r_k <= (r_k == 6'd15) ? 6'd0 : r_k + 6'd1;
                    if (!sw.owner) begin
                        r_n0 <= r_n0 + 5'd1;
                        if (!r_has0 || sw.pos > r_b0) begin
                            r_has0 <= 1'b1;
                            r_b0   <= sw.pos;
                            r_l0   <= r_k[3:0];
                        end
                    end else if (!r_has1 || sw.pos > r_b1) begin
                        r_has1 <= 1'b1;
                        r_b1   <= sw.pos;
                        r_l1   <= r_k[3:0];
                    end
                end
                ST_DIV: begin
                    r_k   <= (r_k == 6'd47) ? 6'd0 : r_k + 6'd1;
                    r_rem <= div_bit ? 32'(div_t - {1'b0, iv_eff}) : div_t[31:0];
                    r_quo <= {r_quo[46:0], div_bit};
                end
                ST_CHK: begin
                    r_k   <= '0;
                    r_acc <= '0;
                    if (r_quo >= r_mark) begin
                        r_rep  <= 1'b1;
                        r_mark <= (r_quo == MARK_MAX) ? MARK_MAX : r_quo + 48'd1;
                    end
                end
                ST_REP1: begin
                    r_p1[r_k[3:0] + 4'd1] <= r_acc + 36'(h1);
                    if (r_k == 6'd14) begin
                        r_k   <= '0;
                        r_acc <= '0;
                    end else begin
                        r_k   <= r_k + 6'd1;
                        r_acc <= r_acc + 36'(h1);
                    end
                end
                ST_REP2: begin
                    r_acc <= s0;
                    if (util_take) begin
                        r_best  <= util;
                        r_bestj <= r_k[3:0] + 4'd1;
                    end
                    if (r_k == 6'd14) begin
                        r_k     <= '0;
                        r_quota <= util_take ? r_k[3:0] + 4'd1 : r_bestj;
                    end else begin
                        r_k <= r_k + 6'd1;
                    end
                end
                ST_APPLY: begin
                    if (out_free) begin
                        r_out.core0_ways <= r_quota;
                        if (r_in.func == FUNC_HIT) begin
                            r_out.victim_way     <= r_in.hit_way;
                            r_out.filled_invalid <= 1'b0;
                            r_out.repartitioned  <= 1'b0;
                            if (!hp[4]) begin
                                if (!r_row[r_in.hit_way].owner) begin
                                    if (h0 != 32'hFFFF_FFFF) begin
                                        r_h0[h_idx] <= h0 + 32'd1;
                                    end
                                end else if (h1 != 32'hFFFF_FFFF) begin
                                    r_h1[h_idx] <= h1 + 32'd1;
                                end
                            end
                        end else begin
                            r_out.victim_way     <= vic;
                            r_out.filled_invalid <= inv_found;
                            r_out.repartitioned  <= r_rep;
                        end
                    end
                end
                default: r_k <= '0;
            endcase
        end
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replacer unit testbench
// Drives hit and fill words into the two-core partition replacer from a
// directed table and then at random, predicts every result from a model of
// the recency, ownership and partition state, and compares field by field.
// ----------------------------------------------------------------------------
module tb;
    import tcupr_pkg::*;

    localparam int NSETS = 1024;
    localparam int LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = CFG_INTERVAL;
    logic [31:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;

    two_core_utility_partition_replacer_unit uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [4:0] rec_pos [NSETS*WAYS];
    logic owner [NSETS*WAYS];
    logic [31:0] hits0 [16];
    logic [31:0] hits1 [16];
    logic [3:0] quota;
    logic [47:0] mark;
    logic [31:0] interval;
    logic [3:0] bottom;

    t_out expected_q [$];
    int errors = 0;
    int n_words = 0, n_results = 0, n_reparts = 0, n_fills = 0;
    int send_pct = 0;
    int recv_pct = 0;
    bit hold_off = 1'b0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;

    task automatic model_reset();
        for (int i = 0; i < NSETS*WAYS; i++) begin
            rec_pos[i] = NEVER_FILLED;
            owner[i] = 1'b0;
        end
        for (int i = 0; i < 16; i++) begin
            hits0[i] = '0;
            hits1[i] = '0;
        end
        quota = QUOTA_RESET;
        mark = 48'd1;
        interval = INTERVAL_RESET;
        bottom = BOTTOM_RESET;
    endtask

    function automatic void place(int base, int way, logic [4:0] target);
        for (int i = 0; i < WAYS; i++) begin
            if (rec_pos[base+i] == target) begin
                rec_pos[base+i] = target + 5'd1;
                break;
            end
        end
        rec_pos[base+way] = target;
    endfunction

    function automatic t_out predict_access(t_in w);
        t_out r;
        int base;
        logic [4:0] p;
        logic [47:0] q;
        logic [63:0] pre0, pre1, u, best;
        int victim, n0, best0, best1, lru0, lru1, take, sb;
        bit found;
        base = int'(w.set_index) * WAYS;
        r = '0;
        r.victim_way = w.hit_way;
        if (w.func == FUNC_HIT) begin
            p = rec_pos[base+w.hit_way];
            if (p < 16) begin
                if (owner[base+w.hit_way] == 1'b0) begin
                    if (hits0[p] != '1) hits0[p]++;
                end else begin
                    if (hits1[p] != '1) hits1[p]++;
                end
            end
            for (int i = 0; i < WAYS; i++)
                if (rec_pos[base+i] < p) rec_pos[base+i]++;
            rec_pos[base+w.hit_way] = '0;
        end else begin
            q = w.cycle_now / ((interval == 0) ? 48'd1 : 48'(interval));
            if (q >= mark) begin
                best = 0;
                for (int j = 1; j < 16; j++) begin
                    pre0 = 0;
                    pre1 = 0;
                    for (int k = 0; k < j; k++) pre0 += hits0[k];
                    for (int k = 0; k < 16 - j; k++) pre1 += hits1[k];
                    u = pre0 + pre1;
                    if (j == 1 || u > best) begin
                        best = u;
                        quota = 4'(j);
                    end
                end
                mark = (q == MARK_MAX) ? MARK_MAX : q + 48'd1;
                r.repartitioned = 1'b1;
            end
            found = 1'b0;
            victim = 0;
            for (int i = 0; i < WAYS; i++) begin
                if (!w.valid_mask[i]) begin
                    victim = i;
                    found = 1'b1;
                    break;
                end
            end
            if (found) begin
                sb = (bottom < 2) ? 2 : int'(bottom);
                r.filled_invalid = 1'b1;
                owner[base+victim] = w.core;
                place(base, victim, 5'(sb - 1));
            end else begin
                n0 = 0; best0 = -1; best1 = -1; lru0 = 0; lru1 = 0;
                for (int i = 0; i < WAYS; i++) begin
                    if (owner[base+i] == 1'b0) begin
                        n0++;
                        if (int'(rec_pos[base+i]) > best0) begin
                            best0 = rec_pos[base+i];
                            lru0 = i;
                        end
                    end else if (int'(rec_pos[base+i]) > best1) begin
                        best1 = rec_pos[base+i];
                        lru1 = i;
                    end
                end
                if (int'(quota) > n0) take = 1;
                else if (int'(quota) < n0) take = 0;
                else take = w.core;
                if (take == 0 && best0 < 0) take = 1;
                if (take == 1 && best1 < 0) take = 0;
                victim = take ? lru1 : lru0;
                owner[base+victim] = w.core;
                if (rec_pos[base+victim] != 0)
                    place(base, victim, rec_pos[base+victim] - 5'd1);
            end
            r.victim_way = 4'(victim);
        end
        r.core0_ways = quota;
        return r;
    endfunction

    task automatic send_word(t_in w);
        @(negedge i_clk);
        while (send_pct > 0 && $urandom_range(99) < send_pct) @(negedge i_clk);
        i_in <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_q.push_back(predict_access(w));
        n_words++;
        if (w.func == FUNC_FILL) n_fills++;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_INTERVAL) interval = data;
        else bottom = data[3:0];
        @(negedge i_clk);
    endtask

    function automatic t_in mk(logic f, int s, int hw, logic c, logic [15:0] vm,
                               logic [47:0] now);
        t_in w;
        w.func = f;
        w.set_index = 10'(s);
        w.hit_way = 4'(hw);
        w.core = c;
        w.valid_mask = vm;
        w.cycle_now = now;
        return w;
    endfunction

    // Random word aimed at a few hot sets so the stacks fill and get reused.
    function automatic t_in rand_word(int hot);
        t_in w;
        w.func = ($urandom_range(99) < 45) ? FUNC_FILL : FUNC_HIT;
        w.set_index = ($urandom_range(9) < 8) ? 10'($urandom_range(hot)) : 10'($urandom);
        w.hit_way = 4'($urandom);
        w.core = 1'($urandom);
        case ($urandom_range(3))
            0: w.valid_mask = 16'($urandom);
            1: w.valid_mask = 16'hFFFF;
            2: w.valid_mask = 16'hFFFF ^ (16'd1 << $urandom_range(15));
            default: w.valid_mask = 16'hFFFF;
        endcase
        w.cycle_now = {16'($urandom), 32'($urandom)};
        if ($urandom_range(3) != 0) w.cycle_now = 48'($urandom_range(4000));
        return w;
    endfunction

    always @(negedge i_clk) begin
        if (hold_off) i_out_ready <= 1'b0;
        else if (recv_pct > 0) i_out_ready <= ($urandom_range(99) >= recv_pct);
        else i_out_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_out);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_out.victim_way !== e.victim_way ||
                    o_out.filled_invalid !== e.filled_invalid ||
                    o_out.repartitioned !== e.repartitioned ||
                    o_out.core0_ways !== e.core0_ways) begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, o_out);
                    errors++;
                end
                if (e.repartitioned) n_reparts++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || hold_off)
            idle_cycles <= 0;
        else if (i_rst_n) idle_cycles <= idle_cycles + 1;
        if (idle_cycles > LIMIT) timed_out <= 1'b1;
    end

    always @(posedge timed_out) begin
        $display("%0t: timeout", $time);
        $display("== FAIL ==");
        $finish;
    end

    typedef struct {
        t_in w;
        bit known;
        t_out r;
    } t_row_stim;

    t_row_stim dir_rows [$];

    initial begin
        t_in w;
        t_out exp_r;
        model_reset();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Directed rows: hits on never-filled ways, invalid fills, full fills.
        exp_r = '{victim_way: 4'd5, filled_invalid: 1'b0, repartitioned: 1'b0,
                  core0_ways: QUOTA_RESET};
        dir_rows.push_back('{mk(FUNC_HIT, 0, 5, 1'b0, 16'h0, 48'd0), 1'b1, exp_r});
        exp_r = '{victim_way: 4'd0, filled_invalid: 1'b1, repartitioned: 1'b0,
                  core0_ways: QUOTA_RESET};
        dir_rows.push_back('{mk(FUNC_FILL, 1023, 15, 1'b1, 16'h0, 48'd0), 1'b1, exp_r});
        exp_r = '{victim_way: 4'd15, filled_invalid: 1'b1, repartitioned: 1'b0,
                  core0_ways: QUOTA_RESET};
        dir_rows.push_back('{mk(FUNC_FILL, 3, 0, 1'b0, 16'h7FFF, 48'd999999), 1'b1, exp_r});
        for (int i = 0; i < 16; i++)
            dir_rows.push_back('{mk(FUNC_FILL, 2, 0, 1'(i % 3 == 0),
                                    ~(16'd1 << i), 48'd5), 1'b0, exp_r});
        dir_rows.push_back('{mk(FUNC_HIT, 2, 3, 1'b0, 16'h0, 48'd0), 1'b0, exp_r});
        dir_rows.push_back('{mk(FUNC_HIT, 2, 9, 1'b1, 16'hFFFF, 48'd0), 1'b0, exp_r});
        dir_rows.push_back('{mk(FUNC_FILL, 2, 0, 1'b1, 16'hFFFF, 48'd1000000), 1'b0, exp_r});
        dir_rows.push_back('{mk(FUNC_FILL, 2, 0, 1'b0, 16'hFFFF, MARK_MAX), 1'b0, exp_r});
        dir_rows.push_back('{mk(FUNC_FILL, 2, 0, 1'b1, 16'hFFFF, MARK_MAX), 1'b0, exp_r});
        foreach (dir_rows[k]) begin
            send_word(dir_rows[k].w);
            if (dir_rows[k].known) begin
                expected_q.pop_back();
                expected_q.push_back(dir_rows[k].r);
            end
        end
        drain();

        // Random phases across register settings, extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_INTERVAL, 32'd0); write_reg(CFG_BOTTOM, 32'd0); end
                1: begin write_reg(CFG_INTERVAL, 32'd1); write_reg(CFG_BOTTOM, 32'd2); end
                2: begin write_reg(CFG_INTERVAL, 32'd97); write_reg(CFG_BOTTOM, 32'd9); end
                3: begin write_reg(CFG_INTERVAL, 32'hFFFFFFFF); write_reg(CFG_BOTTOM, 32'd15); end
                4: begin write_reg(CFG_INTERVAL, 32'd500); write_reg(CFG_BOTTOM, 32'd1); end
                default: begin write_reg(CFG_INTERVAL, 32'd13); write_reg(CFG_BOTTOM, 32'd7); end
            endcase
            if (ph < 2) begin
                send_pct = 26;
                recv_pct = 85;
            end else if (ph < 4) begin
                send_pct = 85;
                recv_pct = 26;
            end else begin
                send_pct = 0;
                recv_pct = 0;
            end
            if (ph == 5) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(negedge i_clk);
                        hold_off = 1'b0;
                    end
                    repeat (6) send_word(rand_word(7));
                join
                drain();
            end
            for (int n = 0; n < 235; n++) begin
                send_word(rand_word((ph % 2) ? 3 : 15));
                if (n == 120) drain();
            end
            drain();
        end

        $display("Sent %0d words (%0d fills), checked %0d results, %0d repartitions.",
                 n_words, n_fills, n_results, n_reparts);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/tcupr_pkg.sv
rtl/two_core_utility_partition_replacer_unit.sv
bench/tb.sv
